// ----- sv/bc7m6_pkg.sv -----
`default_nettype none

package bc7m6_pkg;

    localparam int unsigned TEXELS     = 16;
    localparam int unsigned TEXEL_W    = $clog2(TEXELS);
    localparam int unsigned CHANNELS   = 4;
    localparam int unsigned QUEUE_DEPTH = 2;
    localparam int unsigned QPTR_W     = $clog2(QUEUE_DEPTH);
    localparam int unsigned QCNT_W     = $clog2(QUEUE_DEPTH + 1);

    localparam logic [6:0] MODE6_TAG   = 7'h40;
    localparam logic [6:0] WEIGHT_ONE  = 7'd64;
    localparam logic [14:0] ROUND_HALF = 15'd32;

    localparam logic [6:0] WEIGHTS [TEXELS] = '{
        7'd0,  7'd4,  7'd9,  7'd13, 7'd17, 7'd21, 7'd26, 7'd30,
        7'd34, 7'd38, 7'd43, 7'd47, 7'd51, 7'd55, 7'd60, 7'd64
    };

    // One decoded block, as it waits between the front and the back.
    typedef struct packed {
        logic                        ok;
        logic [CHANNELS-1:0][7:0]    end0;
        logic [CHANNELS-1:0][7:0]    end1;
        logic [TEXELS-1:0][3:0]      idx;
    } t_decoded;

    typedef struct packed {
        logic empty;
        logic full;
    } t_q_status;

endpackage

`default_nettype wire

// ----- sv/bc7_mode6_block_decoder.sv -----
// A taken request is written into the block queue; its texels reach the ports through
// the output registers. Throughput: sixteen texels per block, one per cycle while a block
// is queued, set by the single blend unit that walks the texels of the queued block.
// A two-entry block queue lets requests be taken while a block is still emitting;
// busy is high while that queue is full and throughout reset.
// Reset is synchronous and active low; it empties the queue and clears the strobe.
`default_nettype none

module bc7_mode6_block_decoder
    import bc7m6_pkg::*;
(
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                start,
    output logic                     busy,
    input  wire logic [63:0]         i_block_bits_lo,
    input  wire logic [63:0]         i_block_bits_hi,
    output logic                     o_valid,
    output logic [TEXEL_W-1:0]       o_texel_index,
    output logic [7:0]               o_red,
    output logic [7:0]               o_green,
    output logic [7:0]               o_blue,
    output logic [7:0]               o_alpha,
    output logic                     o_mode_unsupported,
    output logic                     o_last
);

    t_decoded   front_dec;
    t_decoded   head_dec;
    t_q_status  q_status;
    logic       push;
    logic       pop;

    assign busy = q_status.full || !i_rst_n;

    bc7m6_front u_front (
        .i_block_bits_lo (i_block_bits_lo),
        .i_block_bits_hi (i_block_bits_hi),
        .i_take          (start && !busy),
        .o_decoded       (front_dec),
        .o_push          (push)
    );

    bc7m6_queue u_queue (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_push    (push),
        .i_wr_data (front_dec),
        .i_pop     (pop),
        .o_rd_data (head_dec),
        .o_status  (q_status)
    );

    bc7m6_back u_back (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_decoded          (head_dec),
        .i_status           (q_status),
        .o_pop              (pop),
        .o_valid            (o_valid),
        .o_texel_index      (o_texel_index),
        .o_red              (o_red),
        .o_green            (o_green),
        .o_blue             (o_blue),
        .o_alpha            (o_alpha),
        .o_mode_unsupported (o_mode_unsupported),
        .o_last             (o_last)
    );

endmodule

`default_nettype wire

// ----- sv/bc7m6_front.sv -----
`default_nettype none

module bc7m6_front
    import bc7m6_pkg::*;
(
    input  wire logic [63:0] i_block_bits_lo,
    input  wire logic [63:0] i_block_bits_hi,
    input  wire logic        i_take,
    output t_decoded         o_decoded,
    output logic             o_push
);

    always_comb begin
        o_decoded.ok = (i_block_bits_lo[6:0] == MODE6_TAG);
        // Endpoints follow the mode field, pairs per channel; the shared
        // parity bits sit either side of the half boundary.
        for (int ch = 0; ch < CHANNELS; ch++) begin
            o_decoded.end0[ch] = {i_block_bits_lo[7 + 14*ch +: 7], i_block_bits_lo[63]};
            o_decoded.end1[ch] = {i_block_bits_lo[14 + 14*ch +: 7], i_block_bits_hi[0]};
        end
        // The first index loses its top bit, which is implied zero.
        o_decoded.idx[0] = {1'b0, i_block_bits_hi[3:1]};
        for (int i = 1; i < TEXELS; i++) begin
            o_decoded.idx[i] = i_block_bits_hi[4*i +: 4];
        end
    end

    assign o_push = i_take;

endmodule

`default_nettype wire

// ----- sv/bc7m6_queue.sv -----
`default_nettype none

module bc7m6_queue
    import bc7m6_pkg::*;
(
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_push,
    input  wire t_decoded  i_wr_data,
    input  wire logic      i_pop,
    output t_decoded       o_rd_data,
    output t_q_status      o_status
);

    t_decoded            r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   r_wr_ptr, n_wr_ptr;
    logic [QPTR_W-1:0]   r_rd_ptr, n_rd_ptr;
    logic [QCNT_W-1:0]   r_count, n_count;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (!i_push && i_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_wr_data;
        end
    end

    assign o_rd_data      = r_mem[r_rd_ptr];
    assign o_status.empty = (r_count == '0);
    assign o_status.full  = (r_count == QCNT_W'(QUEUE_DEPTH));

endmodule

`default_nettype wire

// ----- sv/bc7m6_back.sv -----
`default_nettype none

module bc7m6_back
    import bc7m6_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire t_decoded           i_decoded,
    input  wire t_q_status          i_status,
    output logic                    o_pop,
    output logic                    o_valid,
    output logic [TEXEL_W-1:0]      o_texel_index,
    output logic [7:0]              o_red,
    output logic [7:0]              o_green,
    output logic [7:0]              o_blue,
    output logic [7:0]              o_alpha,
    output logic                    o_mode_unsupported,
    output logic                    o_last
);

    logic [TEXEL_W-1:0]          r_cnt;
    logic                        r_valid;
    logic [TEXEL_W-1:0]          r_texel;
    logic [CHANNELS-1:0][7:0]    r_chan;
    logic                        r_unsup;
    logic                        r_last;

    logic                        work;
    logic                        at_end;
    logic [6:0]                  weight;
    logic [CHANNELS-1:0][7:0]    n_chan;
    logic [14:0]                 prod0, prod1, total;

    assign work   = !i_status.empty;
    assign at_end = (r_cnt == TEXEL_W'(TEXELS - 1));
    assign o_pop  = work && at_end;
    assign weight = WEIGHTS[i_decoded.idx[r_cnt]];

    always_comb begin
        prod0 = '0;
        prod1 = '0;
        total = '0;
        for (int ch = 0; ch < CHANNELS; ch++) begin
            prod0 = 15'(i_decoded.end0[ch]) * 15'(WEIGHT_ONE - weight);
            prod1 = 15'(i_decoded.end1[ch]) * 15'(weight);
            total = prod0 + prod1 + ROUND_HALF;
            n_chan[ch] = i_decoded.ok ? total[13:6] : 8'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt   <= '0;
            r_valid <= 1'b0;
        end else begin
            r_valid <= work;
            if (work) begin
                r_cnt <= r_cnt + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (work) begin
            r_texel <= r_cnt;
            r_chan  <= n_chan;
            r_unsup <= !i_decoded.ok;
            r_last  <= at_end;
        end
    end

    assign o_valid            = r_valid;
    assign o_texel_index      = r_texel;
    assign o_red              = r_chan[0];
    assign o_green            = r_chan[1];
    assign o_blue             = r_chan[2];
    assign o_alpha            = r_chan[3];
    assign o_mode_unsupported = r_unsup;
    assign o_last             = r_last;

endmodule

`default_nettype wire

// ----- sv/bc7m6_checker.sv -----
`default_nettype none

module bc7m6_checker
    import bc7m6_pkg::*;
(
    input wire logic                i_clk,
    input wire logic                i_rst_n,
    input wire logic                o_valid,
    input wire logic [TEXEL_W-1:0]  o_texel_index,
    input wire logic [7:0]          o_red,
    input wire logic [7:0]          o_green,
    input wire logic [7:0]          o_blue,
    input wire logic [7:0]          o_alpha,
    input wire logic                o_mode_unsupported,
    input wire logic                o_last
);

    // Reset clears the output strobe on the following edge.
    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("strobe seen after reset");

    // The last flag marks the final texel position only.
    a_last_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_last == (o_texel_index == TEXEL_W'(TEXELS - 1))))
        else $error("last flag on wrong texel");

    // Within a block the texels follow one another without gaps.
    a_in_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_last |=> o_valid && (o_texel_index == $past(o_texel_index) + 1'b1))
        else $error("texel sequence broken");

    // The mode flag is the same for every texel of one block.
    a_mode_steady: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_last |=> $stable(o_mode_unsupported))
        else $error("mode flag changed within a block");

    // An unsupported block gives black, transparent texels.
    a_unsup_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_mode_unsupported |->
            (o_red == 8'd0) && (o_green == 8'd0) && (o_blue == 8'd0) && (o_alpha == 8'd0))
        else $error("channels not zero for unsupported mode");

endmodule

bind bc7_mode6_block_decoder bc7m6_checker u_checker (
    .i_clk              (i_clk),
    .i_rst_n            (i_rst_n),
    .o_valid            (o_valid),
    .o_texel_index      (o_texel_index),
    .o_red              (o_red),
    .o_green            (o_green),
    .o_blue             (o_blue),
    .o_alpha            (o_alpha),
    .o_mode_unsupported (o_mode_unsupported),
    .o_last             (o_last)
);

`default_nettype wire

// ----- test/tb_bc7_mode6_block_decoder.sv -----
`timescale 1ns / 1ps

module tb_bc7_mode6_block_decoder;
    import bc7m6_pkg::*;

    localparam int unsigned RANDOM_BLOCKS = 480;
    localparam int unsigned QUIET_TAIL    = 80;
    localparam int unsigned STALL_LIMIT   = 600;
    localparam int unsigned DRAIN_CYCLES  = 40;

    typedef struct packed {
        logic [TEXEL_W-1:0] index;
        logic [3:0][7:0]    chan;
        logic               unsupported;
        logic               last;
    } texel_t;

    class texel_scoreboard;
        texel_t      expected_texels[$];
        int unsigned errors;
        int unsigned mode6_blocks;
        int unsigned other_blocks;
        int unsigned texels_checked;
        int unsigned print_cap = 40;
        int unsigned blend_weight [16] = '{
            0, 4, 9, 13, 17, 21, 26, 30, 34, 38, 43, 47, 51, 55, 60, 64
        };
        string       channel_name [4] = '{"red", "green", "blue", "alpha"};

        task report_mismatch(string msg);
            errors++;
            if (errors <= print_cap) begin
                $display("MISMATCH at %0t: %s", $realtime, msg);
            end
        endtask

        // Works out the sixteen texels that an accepted block must produce.
        function void note_block(logic [63:0] lo, logic [63:0] hi);
            logic [127:0]    blk;
            logic            ok;
            logic [3:0][7:0] end0;
            logic [3:0][7:0] end1;
            logic [3:0]      ix;
            int unsigned     w;
            int unsigned     a;
            int unsigned     b;
            int unsigned     v;
            texel_t          t;
            blk = {hi, lo};
            ok = (blk[6:0] == MODE6_TAG);
            for (int ch = 0; ch < 4; ch++) begin
                end0[ch] = {blk[7 + 14*ch +: 7], blk[63]};
                end1[ch] = {blk[14 + 14*ch +: 7], blk[64]};
            end
            if (ok) mode6_blocks++;
            else other_blocks++;
            for (int i = 0; i < 16; i++) begin
                // Texel 0 carries only three index bits; its top bit is implied zero.
                ix = (i == 0) ? {1'b0, blk[67:65]} : blk[68 + 4*(i-1) +: 4];
                w = blend_weight[ix];
                t.index = TEXEL_W'(i);
                t.unsupported = !ok;
                t.last = (i == 15);
                for (int ch = 0; ch < 4; ch++) begin
                    a = 32'(end0[ch]);
                    b = 32'(end1[ch]);
                    v = (a * (64 - w) + b * w + 32) >> 6;
                    t.chan[ch] = ok ? v[7:0] : 8'd0;
                end
                expected_texels.push_back(t);
            end
        endfunction

        task check_texel(texel_t got);
            texel_t want;
            if (expected_texels.size() == 0) begin
                report_mismatch($sformatf("texel %0d arrived with no block pending",
                                          got.index));
                return;
            end
            want = expected_texels.pop_front();
            texels_checked++;
            if (got.index !== want.index)
                report_mismatch($sformatf("texel index: got %0d, expected %0d",
                                          got.index, want.index));
            for (int ch = 0; ch < 4; ch++) begin
                if (got.chan[ch] !== want.chan[ch])
                    report_mismatch($sformatf("texel %0d %s: got %0d, expected %0d",
                                              want.index, channel_name[ch],
                                              got.chan[ch], want.chan[ch]));
            end
            if (got.unsupported !== want.unsupported)
                report_mismatch($sformatf("texel %0d mode flag: got %b, expected %b",
                                          want.index, got.unsupported, want.unsupported));
            if (got.last !== want.last)
                report_mismatch($sformatf("texel %0d last: got %b, expected %b",
                                          want.index, got.last, want.last));
        endtask
    endclass

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               start = 1'b0;
    logic [63:0]        i_block_bits_lo = '0;
    logic [63:0]        i_block_bits_hi = '0;
    logic               busy;
    logic               o_valid;
    logic [TEXEL_W-1:0] o_texel_index;
    logic [7:0]         o_red;
    logic [7:0]         o_green;
    logic [7:0]         o_blue;
    logic [7:0]         o_alpha;
    logic               o_mode_unsupported;
    logic               o_last;

    texel_scoreboard sb;
    texel_t          seen_texel;
    int unsigned     quiet_cycles = 0;

    bc7_mode6_block_decoder uut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .start              (start),
        .busy               (busy),
        .i_block_bits_lo    (i_block_bits_lo),
        .i_block_bits_hi    (i_block_bits_hi),
        .o_valid            (o_valid),
        .o_texel_index      (o_texel_index),
        .o_red              (o_red),
        .o_green            (o_green),
        .o_blue             (o_blue),
        .o_alpha            (o_alpha),
        .o_mode_unsupported (o_mode_unsupported),
        .o_last             (o_last)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid) begin
            seen_texel.index = o_texel_index;
            seen_texel.chan = {o_alpha, o_blue, o_green, o_red};
            seen_texel.unsupported = o_mode_unsupported;
            seen_texel.last = o_last;
            sb.check_texel(seen_texel);
        end
    end

    // Ends the run when neither a request nor a texel has moved for too long.
    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_valid) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles == STALL_LIMIT) begin
            $display("Timeout: nothing moved for %0d cycles", STALL_LIMIT);
            $display("DONE: errors detected");
            $finish;
        end
    end

    function automatic logic [127:0] mode6_block(logic [3:0][6:0] s0, logic [3:0][6:0] s1,
                                                 logic p0, logic p1, logic [15:0][3:0] ix);
        logic [127:0] blk;
        blk = '0;
        blk[6:0] = MODE6_TAG;
        for (int ch = 0; ch < 4; ch++) begin
            blk[7 + 14*ch +: 7] = s0[ch];
            blk[14 + 14*ch +: 7] = s1[ch];
        end
        blk[63] = p0;
        blk[64] = p1;
        blk[67:65] = ix[0][2:0];
        for (int i = 1; i < 16; i++) begin
            blk[68 + 4*(i-1) +: 4] = ix[i];
        end
        return blk;
    endfunction

    // Holds the request up from the next falling edge until the block takes it.
    task send_block(logic [127:0] blk);
        @(negedge i_clk);
        start = 1'b1;
        i_block_bits_lo = blk[63:0];
        i_block_bits_hi = blk[127:64];
        do @(posedge i_clk); while (busy);
        sb.note_block(blk[63:0], blk[127:64]);
    endtask

    task idle_cycles(int unsigned n);
        repeat (n) begin
            @(negedge i_clk);
            start = 1'b0;
            i_block_bits_lo = {$urandom, $urandom};
            i_block_bits_hi = {$urandom, $urandom};
        end
    endtask

    task maybe_idle(bit allowed);
        if (allowed && $urandom_range(0, 99) < 35)
            idle_cycles($urandom_range(1, 13));
    endtask

    task directed_blocks();
        logic [15:0][3:0] ascending;
        logic [15:0][3:0] descending;
        logic [127:0]     blk;
        logic [6:0]       other_modes [11] = '{
            7'h00, 7'h01, 7'h02, 7'h04, 7'h08, 7'h10, 7'h20, 7'h41, 7'h60, 7'h7F, 7'h48
        };
        for (int i = 0; i < 16; i++) begin
            ascending[i] = 4'(i);
            descending[i] = 4'(15 - i);
        end
        descending[0] = 4'd7;
        send_block(mode6_block('0, '0, 1'b0, 1'b0, '0));
        send_block(mode6_block('1, '1, 1'b1, 1'b1, '1));
        // Every weight, from full first endpoint to full second endpoint.
        for (int p = 0; p < 4; p++) begin
            send_block(mode6_block('0, '1, p[0], p[1], ascending));
            maybe_idle(1'b1);
        end
        send_block(mode6_block('1, '0, 1'b1, 1'b0, descending));
        send_block(mode6_block({7'h7F, 7'h00, 7'h55, 7'h2A}, {7'h00, 7'h7F, 7'h2A, 7'h55},
                               1'b0, 1'b1, ascending));
        // Blocks whose mode field is anything other than mode 6.
        foreach (other_modes[k]) begin
            blk = {$urandom, $urandom, $urandom, $urandom};
            blk[6:0] = other_modes[k];
            send_block(blk);
            maybe_idle(k % 3 == 0);
        end
        send_block('1);
        send_block('0);
    endtask

    initial begin
        logic [127:0] blk;
        int unsigned  kind;
        bit           gaps_on;
        sb = new();
        repeat (9) @(negedge i_clk);
        i_rst_n = 1'b1;

        directed_blocks();
        idle_cycles(3);

        for (int n = 0; n < RANDOM_BLOCKS; n++) begin
            if (n % 40 == 0) gaps_on = ($urandom_range(0, 3) != 0);
            kind = $urandom_range(0, 99);
            blk = {$urandom, $urandom, $urandom, $urandom};
            if (kind < 80) begin
                blk[6:0] = MODE6_TAG;
                if (kind < 6) blk[62:7] = {56{kind[0]}};
            end else if (kind < 90) begin
                blk[6:0] = MODE6_TAG ^ (7'd1 << $urandom_range(0, 6));
            end
            // The remaining requests are raw noise, nearly always some other mode.
            send_block(blk);
            maybe_idle(gaps_on && n < RANDOM_BLOCKS - QUIET_TAIL);
        end
        @(negedge i_clk);
        start = 1'b0;

        while (sb.expected_texels.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Checked %0d texels from %0d mode 6 blocks and %0d blocks of other modes.",
                 sb.texels_checked, sb.mode6_blocks, sb.other_blocks);
        $display("Requests came with random gaps, back to back, and with both parities.");
        if (sb.errors == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
